// ===== design/dvt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvt_pkg
// Shared types and constants for the divider and reloading timer core.
// ----------------------------------------------------------------------------
package dvt_pkg;

  // phase accumulators are 12-bit two's complement
  localparam int unsigned PhaseW = 12;
  localparam logic signed [PhaseW-1:0] PhaseFloor = {1'b1, {(PhaseW-1){1'b0}}};

  // item kinds
  localparam logic [1:0] ActAdvance = 2'd0;
  localparam logic [1:0] ActWrite   = 2'd1;
  localparam logic [1:0] ActRead    = 2'd2;

  // register selects
  localparam logic [1:0] RegDivider = 2'd0;
  localparam logic [1:0] RegCounter = 2'd1;
  localparam logic [1:0] RegReload  = 2'd2;
  localparam logic [1:0] RegControl = 2'd3;

  // control register bits
  localparam int unsigned CtrlEnableBit = 2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] cycle_count;
    logic [1:0] register_select;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_interrupt;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // take a new item
    logic step;    // one phase step of each running accumulator
    logic finish;  // move the result into the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;    // an accumulator still has steps to do
  } dp_status_t;

endpackage

// ===== design/dvt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvt_ctrl
// Controller: sequences load, phase steps and result hand-off, and owns the
// handshake state of both channels.
// ----------------------------------------------------------------------------
module dvt_ctrl
  import dvt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  localparam logic [0:0] StIdle = 1'b0;
  localparam logic [0:0] StRun  = 1'b1;

  logic [0:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.step   = 1'b0;
    cmd_o.finish = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        if (status_i.busy) begin
          cmd_o.step = 1'b1;
        end else if (slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // output valid: set on finish, cleared on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/dvt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvt_datapath
// Timer registers, the two phase accumulators with their step units, and the
// output register.
// ----------------------------------------------------------------------------
module dvt_datapath
  import dvt_pkg::*;
#(
  parameter int unsigned DIV_PERIOD   = 256,
  parameter int unsigned RATE0_PERIOD = 1024,
  parameter int unsigned RATE1_PERIOD = 16,
  parameter int unsigned RATE2_PERIOD = 64,
  parameter int unsigned RATE3_PERIOD = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   item_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output out_item_t  result_o
);

  localparam logic signed [PhaseW-1:0] DivPeriod = PhaseW'(DIV_PERIOD);
  localparam logic signed [PhaseW-1:0] Rate0     = PhaseW'(RATE0_PERIOD);
  localparam logic signed [PhaseW-1:0] Rate1     = PhaseW'(RATE1_PERIOD);
  localparam logic signed [PhaseW-1:0] Rate2     = PhaseW'(RATE2_PERIOD);
  localparam logic signed [PhaseW-1:0] Rate3     = PhaseW'(RATE3_PERIOD);

  function automatic logic signed [PhaseW-1:0] rate_period(input logic [1:0] sel);
    logic signed [PhaseW-1:0] p;
    unique case (sel)
      2'd0:    p = Rate0;
      2'd1:    p = Rate1;
      2'd2:    p = Rate2;
      default: p = Rate3;
    endcase
    return p;
  endfunction

  // subtract an 8-bit count, saturating at the phase floor
  function automatic logic signed [PhaseW-1:0] phase_sub(
    input logic signed [PhaseW-1:0] phase,
    input logic [7:0]               amount
  );
    logic signed [PhaseW:0] diff;
    diff = {phase[PhaseW-1], phase} - $signed({{(PhaseW-7){1'b0}}, amount});
    return (diff < $signed({PhaseFloor[PhaseW-1], PhaseFloor})) ?
           PhaseFloor : diff[PhaseW-1:0];
  endfunction

  function automatic logic not_positive(input logic signed [PhaseW-1:0] phase);
    return phase[PhaseW-1] || (phase == '0);
  endfunction

  logic [7:0]               div_q, div_d;
  logic signed [PhaseW-1:0] div_phase_q, div_phase_d;
  logic [7:0]               cnt_q, cnt_d;
  logic [7:0]               reload_q, reload_d;
  logic [2:0]               ctrl_q, ctrl_d;
  logic signed [PhaseW-1:0] cnt_phase_q, cnt_phase_d;
  logic                     div_run_q, div_run_d;
  logic                     cnt_run_q, cnt_run_d;
  logic [7:0]               rd_q, rd_d;
  logic                     irq_q, irq_d;
  out_item_t                result_q;

  logic signed [PhaseW-1:0] div_phase_sub, cnt_phase_sub;
  logic signed [PhaseW-1:0] div_phase_add, cnt_phase_add;
  logic [7:0]               div_inc;

  assign status_o.busy = div_run_q || cnt_run_q;
  assign result_o      = result_q;

  assign div_phase_sub = phase_sub(div_phase_q, item_i.cycle_count);
  assign cnt_phase_sub = phase_sub(cnt_phase_q, item_i.cycle_count);
  assign div_phase_add = div_phase_q + DivPeriod;
  assign cnt_phase_add = cnt_phase_q + rate_period(ctrl_q[1:0]);
  assign div_inc       = div_q + 8'd1;

  // item load and accumulator steps
  always_comb begin
    div_d       = div_q;
    div_phase_d = div_phase_q;
    cnt_d       = cnt_q;
    reload_d    = reload_q;
    ctrl_d      = ctrl_q;
    cnt_phase_d = cnt_phase_q;
    div_run_d   = div_run_q;
    cnt_run_d   = cnt_run_q;
    rd_d        = rd_q;
    irq_d       = irq_q;
    if (cmd_i.load) begin
      rd_d  = '0;
      irq_d = 1'b0;
      unique case (item_i.action)
        ActAdvance: begin
          div_phase_d = div_phase_sub;
          div_run_d   = not_positive(div_phase_sub);
          if (ctrl_q[CtrlEnableBit]) begin
            cnt_phase_d = cnt_phase_sub;
            cnt_run_d   = not_positive(cnt_phase_sub);
          end
        end
        ActWrite: begin
          unique case (item_i.register_select)
            RegDivider: div_d    = '0;
            RegCounter: cnt_d    = item_i.write_data;
            RegReload:  reload_d = item_i.write_data;
            default: begin
              ctrl_d      = item_i.write_data[2:0];
              cnt_phase_d = rate_period(item_i.write_data[1:0]);
            end
          endcase
        end
        ActRead: begin
          unique case (item_i.register_select)
            RegDivider: rd_d = div_q;
            RegCounter: rd_d = cnt_q;
            RegReload:  rd_d = reload_q;
            default:    rd_d = {5'd0, ctrl_q};
          endcase
        end
        default: ;
      endcase
    end else if (cmd_i.step) begin
      // divider: one period per step, stop on wrap or positive phase
      if (div_run_q) begin
        div_phase_d = div_phase_add;
        div_d       = div_inc;
        div_run_d   = (div_inc != 8'd0) && not_positive(div_phase_add);
      end
      // counter: one period per step, reload and flag on wrap
      if (cnt_run_q) begin
        cnt_phase_d = cnt_phase_add;
        if (cnt_q == 8'hFF) begin
          cnt_d     = reload_q;
          irq_d     = 1'b1;
          cnt_run_d = 1'b0;
        end else begin
          cnt_d     = cnt_q + 8'd1;
          cnt_run_d = not_positive(cnt_phase_add);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q       <= '0;
      div_phase_q <= DivPeriod;
      cnt_q       <= '0;
      reload_q    <= '0;
      ctrl_q      <= '0;
      cnt_phase_q <= Rate0;
      div_run_q   <= 1'b0;
      cnt_run_q   <= 1'b0;
    end else begin
      div_q       <= div_d;
      div_phase_q <= div_phase_d;
      cnt_q       <= cnt_d;
      reload_q    <= reload_d;
      ctrl_q      <= ctrl_d;
      cnt_phase_q <= cnt_phase_d;
      div_run_q   <= div_run_d;
      cnt_run_q   <= cnt_run_d;
    end
  end

  // result payload registers
  always_ff @(posedge clk_i) begin
    rd_q  <= rd_d;
    irq_q <= irq_d;
    if (cmd_i.finish) begin
      result_q.read_data       <= rd_q;
      result_q.timer_interrupt <= irq_q;
    end
  end

endmodule

// ===== design/divider_and_reloading_timer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divider_and_reloading_timer_core
// Timer with free-running divider, enabled counter with reload and interrupt
// flag; items are advances, register writes and register reads.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (in_item_t)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (out_item_t)
//
//  An item is loaded, then takes S phase steps, then is handed off.
//  S is the larger of the divider and counter step counts of an advance
//  (one period added per cycle, at most 256 each) and 0 for reads/writes.
//  Reset puts the divider phase at DIV_PERIOD and counter phase at RATE0.
//  A new item is taken while a finished result waits in the output register;
//  hand-off stalls only when that register is still full.
// ----------------------------------------------------------------------------
module divider_and_reloading_timer_core
  import dvt_pkg::*;
#(
  parameter int unsigned DIV_PERIOD   = 256,
  parameter int unsigned RATE0_PERIOD = 1024,
  parameter int unsigned RATE1_PERIOD = 16,
  parameter int unsigned RATE2_PERIOD = 64,
  parameter int unsigned RATE3_PERIOD = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing
  dvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // timer registers and step units
  dvt_datapath #(
    .DIV_PERIOD   (DIV_PERIOD),
    .RATE0_PERIOD (RATE0_PERIOD),
    .RATE1_PERIOD (RATE1_PERIOD),
    .RATE2_PERIOD (RATE2_PERIOD),
    .RATE3_PERIOD (RATE3_PERIOD)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_data_i),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (out_data_o)
  );

endmodule
